// File: src/assert_macros.svh
// Assertion macros for the RTL file of the colour converter.
// Each macro samples on the rising edge of clock and is disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: whenever cond holds, expr holds.
`define ASSERT_IMP(lbl, cond, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error("assertion failed: implication");

// Next-cycle implication: whenever cond holds, expr holds in the next cycle.
`define ASSERT_NEXT(lbl, cond, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error("assertion failed: next-cycle implication");

`endif

// File: src/hsl_pkg.sv
// Constants and sector codes for the HSL to RGB / PWM compare pipeline.
// No dependencies.
package hsl_pkg;

   // Fixed point one, Q1.20
   localparam logic [20:0] FX_ONE      = 21'd1048576;
   // Hue saturates at 360 degrees
   localparam logic [28:0] HUE_MAX     = 29'd377487360;
   // round(2^20 / 60)
   localparam logic [14:0] RECIP_60    = 15'd17476;
   // Reset value of the PWM load and the scale derived from it
   localparam logic [15:0] LOAD_RESET  = 16'd10000;
   localparam logic [15:0] SCALE_RESET = LOAD_RESET - 16'd1;
   // Largest channel intensity
   localparam logic [7:0]  CHAN_MAX    = 8'd255;

   // Hue sectors of sixty degrees each
   localparam logic [2:0] SECTOR_0 = 3'd0;
   localparam logic [2:0] SECTOR_1 = 3'd1;
   localparam logic [2:0] SECTOR_2 = 3'd2;
   localparam logic [2:0] SECTOR_3 = 3'd3;
   localparam logic [2:0] SECTOR_4 = 3'd4;
   localparam logic [2:0] SECTOR_5 = 3'd5;

endpackage

// File: src/hsl_to_rgb_pwm_compare.sv
// HSL to RGB conversion with PWM compare scaling, six-stage pipeline.
// Each accepted input beat is registered in stages 1 to 6 in turn; the result beat leaves stage 6.
// Throughput: one colour per cycle when not stalled; bubbles collapse, a result stall holds only full stages.
// Long paths: one 16x16 multiply per stage (chroma, X), then *255 and *scale.
// Reset (synchronous, active high) empties the pipeline and sets the scale for pwm_load = 10000 (scale 9999).
// Depends on hsl_pkg and assert_macros.svh.
`include "assert_macros.svh"

module hsl_to_rgb_pwm_compare (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [28:0] req_hue,
   input  logic [20:0] req_saturation,
   input  logic [20:0] req_lightness,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic [15:0] rsp_red_compare,
   output logic [15:0] rsp_green_compare,
   output logic [15:0] rsp_blue_compare,
   // configuration
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   // ---------------------------------------------------------------
   // Configuration: keep load-1 (zero for a load of zero)
   // ---------------------------------------------------------------
   logic [15:0] scale_ff;
   logic [15:0] scale_in;

   assign scale_in = (csr_wr_data == 16'd0) ? 16'd0 : csr_wr_data - 16'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= hsl_pkg::SCALE_RESET;
      end else if (csr_wr_en) begin
         scale_ff <= scale_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage valids and enables; a stage advances when empty or when
   // the stage after it advances
   // ---------------------------------------------------------------
   logic [6:1] valid_ff;
   logic [6:1] stage_en;

   always_comb begin
      stage_en[6] = !valid_ff[6] || !rsp_stall;
      for (int k = 5; k >= 1; k--) begin
         stage_en[k] = !valid_ff[k] || stage_en[k+1];
      end
   end

   assign req_stall = !stage_en[1];
   assign rsp_valid = valid_ff[6];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (stage_en[1]) begin
            valid_ff[1] <= req_valid;
         end
         for (int k = 2; k <= 6; k++) begin
            if (stage_en[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Stage 1: saturate inputs, lightness term (ONE-|2L-ONE|)>>5
   // ---------------------------------------------------------------
   logic [28:0] hue_sat;
   logic [20:0] sat_sat;
   logic [20:0] light_sat;
   logic [21:0] light_twice;
   logic [21:0] light_dev;
   logic [21:0] light_rem;
   logic [13:0] h15_ff;
   logic [15:0] s5_ff;
   logic [15:0] lterm_ff;
   logic [20:0] l1_ff;

   always_comb begin
      hue_sat     = (req_hue > hsl_pkg::HUE_MAX) ? hsl_pkg::HUE_MAX : req_hue;
      sat_sat     = (req_saturation > hsl_pkg::FX_ONE) ? hsl_pkg::FX_ONE : req_saturation;
      light_sat   = (req_lightness > hsl_pkg::FX_ONE) ? hsl_pkg::FX_ONE : req_lightness;
      light_twice = {light_sat, 1'b0};
      light_dev   = (light_twice >= 22'(hsl_pkg::FX_ONE)) ?
                    light_twice - 22'(hsl_pkg::FX_ONE) :
                    22'(hsl_pkg::FX_ONE) - light_twice;
      light_rem   = 22'(hsl_pkg::FX_ONE) - light_dev;
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         h15_ff   <= hue_sat[28:15];
         s5_ff    <= sat_sat[20:5];
         lterm_ff <= light_rem[20:5];
         l1_ff    <= light_sat;
      end
   end

   // ---------------------------------------------------------------
   // Stage 2: chroma and hue fraction products
   // ---------------------------------------------------------------
   logic [31:0] chroma_prod;
   logic [28:0] hue_prod;
   logic [20:0] c2_ff;
   logic [22:0] hf2_ff;
   logic [20:0] l2_ff;

   assign chroma_prod = 32'(lterm_ff) * 32'(s5_ff);
   assign hue_prod    = 29'(h15_ff) * 29'(hsl_pkg::RECIP_60);

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         c2_ff  <= chroma_prod[30:10];
         hf2_ff <= hue_prod[27:5];
         l2_ff  <= l1_ff;
      end
   end

   // ---------------------------------------------------------------
   // Stage 3: X factor, sector (six and seven fold to zero) and m = L - C/2
   // ---------------------------------------------------------------
   logic [20:0] frac_md;
   logic [20:0] frac_dev;
   logic [20:0] frac_rem;
   logic [2:0]  sector_raw;
   logic [2:0]  sector_in;
   logic [15:0] xf3_ff;
   logic [15:0] c5_3_ff;
   logic [20:0] c3_ff;
   logic signed [21:0] m3_ff;
   logic [2:0]  sec3_ff;
   logic signed [21:0] m_in;

   always_comb begin
      frac_md    = hf2_ff[20:0];
      frac_dev   = (frac_md >= hsl_pkg::FX_ONE) ? frac_md - hsl_pkg::FX_ONE :
                   hsl_pkg::FX_ONE - frac_md;
      frac_rem   = hsl_pkg::FX_ONE - frac_dev;
      sector_raw = hf2_ff[22:20];
      sector_in  = (sector_raw > hsl_pkg::SECTOR_5) ? hsl_pkg::SECTOR_0 : sector_raw;
      m_in       = $signed({1'b0, l2_ff}) - $signed({2'b00, c2_ff[20:1]});
   end

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         xf3_ff  <= frac_rem[20:5];
         c5_3_ff <= c2_ff[20:5];
         c3_ff   <= c2_ff;
         m3_ff   <= m_in;
         sec3_ff <= sector_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage 4: X = (C>>5) * factor >> 10
   // ---------------------------------------------------------------
   logic [31:0] x_prod;
   logic [20:0] x4_ff;
   logic [20:0] c4_ff;
   logic signed [21:0] m4_ff;
   logic [2:0]  sec4_ff;

   assign x_prod = 32'(c5_3_ff) * 32'(xf3_ff);

   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         x4_ff   <= x_prod[30:10];
         c4_ff   <= c3_ff;
         m4_ff   <= m3_ff;
         sec4_ff <= sec3_ff;
      end
   end

   // ---------------------------------------------------------------
   // Stage 5: sector pattern, add m, scale by 255
   // ---------------------------------------------------------------
   logic [20:0] part [3];
   logic signed [22:0] part_sum [3];
   logic signed [30:0] v5_in [3];
   logic signed [30:0] v5_ff [3];

   always_comb begin
      case (sec4_ff)
         hsl_pkg::SECTOR_1: begin
            part[0] = x4_ff; part[1] = c4_ff; part[2] = '0;
         end
         hsl_pkg::SECTOR_2: begin
            part[0] = '0;    part[1] = c4_ff; part[2] = x4_ff;
         end
         hsl_pkg::SECTOR_3: begin
            part[0] = '0;    part[1] = x4_ff; part[2] = c4_ff;
         end
         hsl_pkg::SECTOR_4: begin
            part[0] = x4_ff; part[1] = '0;    part[2] = c4_ff;
         end
         hsl_pkg::SECTOR_5: begin
            part[0] = c4_ff; part[1] = '0;    part[2] = x4_ff;
         end
         default: begin
            part[0] = c4_ff; part[1] = x4_ff; part[2] = '0;
         end
      endcase
      for (int k = 0; k < 3; k++) begin
         part_sum[k] = $signed({2'b00, part[k]}) + $signed({m4_ff[21], m4_ff});
         v5_in[k]    = $signed({{8{part_sum[k][22]}}, part_sum[k]}) * 31'sd255;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[5]) begin
         for (int k = 0; k < 3; k++) begin
            v5_ff[k] <= v5_in[k];
         end
      end
   end

   // ---------------------------------------------------------------
   // Stage 6: clamp to 0..255, compare = chan * (load-1) / 256
   // ---------------------------------------------------------------
   logic [10:0] chan_shift [3];
   logic [7:0]  chan_in [3];
   logic [23:0] cmp_prod [3];
   logic [7:0]  chan_ff [3];
   logic [15:0] cmp_ff [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         chan_shift[k] = v5_ff[k][30:20];
         if (v5_ff[k][30]) begin
            chan_in[k] = '0;
         end else if (chan_shift[k] > 11'(hsl_pkg::CHAN_MAX)) begin
            chan_in[k] = hsl_pkg::CHAN_MAX;
         end else begin
            chan_in[k] = chan_shift[k][7:0];
         end
         cmp_prod[k] = 24'(chan_in[k]) * 24'(scale_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[6]) begin
         for (int k = 0; k < 3; k++) begin
            chan_ff[k] <= chan_in[k];
            cmp_ff[k]  <= cmp_prod[k][23:8];
         end
      end
   end

   assign rsp_red           = chan_ff[0];
   assign rsp_green         = chan_ff[1];
   assign rsp_blue          = chan_ff[2];
   assign rsp_red_compare   = cmp_ff[0];
   assign rsp_green_compare = cmp_ff[1];
   assign rsp_blue_compare  = cmp_ff[2];

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   `ASSERT_NEXT(a_accept_fills_stage1, req_valid && !req_stall, valid_ff[1])
   `ASSERT_IMP(a_full_stall_backs_up, (&valid_ff) && rsp_stall, req_stall)
   `ASSERT_IMP(a_sector_repaired, valid_ff[3], sec3_ff <= hsl_pkg::SECTOR_5)
   `ASSERT_IMP(a_dark_red_zero_cmp, rsp_valid && (rsp_red == 8'd0), rsp_red_compare == 16'd0)

endmodule
